// ===== design/touch_calibrate_and_map_defines.svh =====
// Assertion macros for the touch calibration block.
`ifndef TOUCH_CALIBRATE_AND_MAP_DEFINES_SVH
`define TOUCH_CALIBRATE_AND_MAP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TCM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TCM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tcm_pkg.sv =====
// Shared types and constants for the touch calibration block.
`timescale 1ns / 1ps
`default_nettype none
package tcm_pkg;

	localparam int RAW_BITS      = 12;
	localparam int SCR_BITS      = 12;
	localparam int SCALE_BITS    = 32;
	localparam int CNT_BITS      = 3;
	localparam int DEN_BITS      = 14;
	localparam int MAX_POINTS    = 7;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_IDX_BITS  = 2;

	localparam logic [RAW_BITS:0] RAW_MID = (RAW_BITS + 1)'(1 << (RAW_BITS - 1));

	localparam logic [SCR_BITS-1:0] SCREEN_W_RST = 12'd320;
	localparam logic [SCR_BITS-1:0] SCREEN_H_RST = 12'd240;

	localparam logic [CFG_IDX_BITS-1:0] REG_POINT_COUNT  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd2;

	typedef struct packed {
		logic [SCR_BITS-1:0] target_y;
		logic [SCR_BITS-1:0] target_x;
		logic                pen_up;
		logic [RAW_BITS-1:0] raw_y;
		logic [RAW_BITS-1:0] raw_x;
	} in_item_t;

	typedef struct packed {
		logic                calib_ok;
		logic [SCR_BITS-1:0] pos_y;
		logic [SCR_BITS-1:0] pos_x;
		logic                touch_valid;
	} out_item_t;

	// Result of one mapped axis.
	typedef struct packed {
		logic                valid;
		logic                axis_y;
		logic [SCR_BITS-1:0] pos;
	} map_res_t;

endpackage
`default_nettype wire

// ===== design/tcm_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tcm_div #(
	parameter int NUM_BITS = 28,
	parameter int DEN_BITS = 14
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [NUM_BITS-1:0] dividend,
	input  wire logic [DEN_BITS-1:0] divisor,
	output logic                     done,
	output logic [NUM_BITS-1:0]      quotient
);
	localparam int CW = $clog2(NUM_BITS);

	logic                busy_q;
	logic                done_q;
	logic [CW-1:0]       cnt_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [DEN_BITS:0]   rem_sh;
	logic [DEN_BITS:0]   diff;
	logic                qbit;
	logic [DEN_BITS-1:0] rem_next;

	always_comb begin
		rem_sh   = {rem_q, quo_q[NUM_BITS-1]};
		diff     = rem_sh - {1'b0, den_q};
		qbit     = ~diff[DEN_BITS];
		rem_next = qbit ? diff[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[NUM_BITS-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ===== design/tcm_mapper.sv =====
// Two-stage axis mapper: centre and multiply, then round, offset and clamp.
`timescale 1ns / 1ps
`default_nettype none
module tcm_mapper #(
	parameter int FRAC_BITS = tcm_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic                                axis_y,
	input  wire logic [tcm_pkg::RAW_BITS-1:0]        raw,
	input  wire logic [tcm_pkg::SCALE_BITS-1:0]      scale,
	input  wire logic [tcm_pkg::SCR_BITS-1:0]        origin,
	output tcm_pkg::map_res_t                        res
);
	import tcm_pkg::*;

	localparam int PW = RAW_BITS + 1 + SCALE_BITS;
	localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) <<< (FRAC_BITS - 1);

	logic signed [RAW_BITS:0] cen;
	logic signed [PW-1:0]     prod_s1;
	logic [SCR_BITS-1:0]      origin_s1;
	logic                     axis_s1;
	logic                     valid_s1;
	logic signed [PW-1:0]     rnd;
	logic signed [PW-1:0]     rsh;
	logic signed [PW:0]       pos_w;
	logic signed [PW:0]       hi_w;
	logic [SCR_BITS-1:0]      pos_c;
	map_res_t                 res_q;

	assign cen = $signed({1'b0, raw} - RAW_MID);

	always_comb begin
		rnd   = prod_s1 + ROUND_HALF;
		rsh   = rnd >>> FRAC_BITS;
		pos_w = (PW + 1)'(rsh) + $signed({{(PW + 1 - SCR_BITS){1'b0}}, origin_s1});
		hi_w  = $signed({{(PW - SCR_BITS){1'b0}}, origin_s1, 1'b0}) - (PW + 1)'(1);
		if (origin_s1 == '0) begin
			pos_c = '0;
		end else if (pos_w[PW]) begin
			pos_c = '0;
		end else if (pos_w > hi_w) begin
			pos_c = hi_w[SCR_BITS-1:0];
		end else begin
			pos_c = pos_w[SCR_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_q    <= '0;
		end else begin
			valid_s1     <= start;
			res_q.valid  <= valid_s1;
			res_q.axis_y <= axis_s1;
			res_q.pos    <= pos_c;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1   <= cen * $signed(scale);
		origin_s1 <= origin;
		axis_s1   <= axis_y;
	end

	assign res = res_q;

endmodule
`default_nettype wire

// ===== design/touch_calibrate_and_map.sv =====
// Top level: touch calibration sequencer, mapping and stream ports.
// Usage:
//   Items enter on s_axis; tuser carries cmd (0 map a sample, 1 calibration
//   point). One result leaves on m_axis per item; tlast is calib_done.
//   cfg_* writes point_count (0), screen_width (1), screen_height (2), always
//   ready. The user must write it only while the block is idle; not enforced.
// Sequencing:
//   A sample runs from acceptance to the output register through the mapper,
//   one multiplier used for X then Y. A pen-up sample skips the mapper.
//   A calibration point uses one serial divider, which produces FRAC_BITS+12
//   quotient bits for X, then for Y.
//   s_axis_tready is high only between items, one item at a time.
// Stall:
//   A finished result waits in the output register; the next item is still
//   accepted and runs, and its result holds until the register frees.
// Reset:
//   Scales, origins, sums and run progress clear; screen size returns to
//   320x240, point_count to 0. Mapping gives 0 on uncalibrated axes.
`timescale 1ns / 1ps
`default_nettype none
`include "touch_calibrate_and_map_defines.svh"
module touch_calibrate_and_map #(
	parameter int FRAC_BITS = tcm_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// raw_x, raw_y, pen_up, target_x, target_y, zero fill
	input  wire logic [55:0]                          s_axis_tdata,
	// cmd
	input  wire logic                                 s_axis_tuser,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// touch_valid, pos_x, pos_y, calib_ok, zero fill
	output logic [31:0]                               m_axis_tdata,
	// calib_done
	output logic                                      m_axis_tlast,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [tcm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire logic [tcm_pkg::SCR_BITS-1:0]         cfg_data
);
	import tcm_pkg::*;

	localparam int NUM_BITS = SCR_BITS + FRAC_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_MAP_X, S_MAP_Y, S_MAP_WAIT, S_CAL,
		S_DIV_X, S_WAIT_X, S_DIV_Y, S_WAIT_Y, S_END, S_EMIT
	} state_t;

	state_t                  state_q;
	in_item_t                item_q;
	out_item_t               res_q;
	logic                    res_done_q;
	out_item_t               out_q;
	logic                    out_valid_q;
	logic                    out_last_q;

	logic [CNT_BITS-1:0]     point_count_q;
	logic [SCR_BITS-1:0]     screen_w_q;
	logic [SCR_BITS-1:0]     screen_h_q;
	logic [SCALE_BITS-1:0]   scale_x_q;
	logic [SCALE_BITS-1:0]   scale_y_q;
	logic [SCR_BITS-1:0]     origin_x_q;
	logic [SCR_BITS-1:0]     origin_y_q;
	logic [SCALE_BITS-1:0]   sum_x_q;
	logic [SCALE_BITS-1:0]   sum_y_q;
	logic [CNT_BITS-1:0]     points_seen_q;
	logic                    run_failed_q;

	in_item_t                in_item;
	logic [SCR_BITS-1:0]     mid_x;
	logic [SCR_BITS-1:0]     mid_y;
	logic signed [SCR_BITS:0] sx;
	logic signed [SCR_BITS:0] sy;
	logic signed [RAW_BITS:0] tx;
	logic signed [RAW_BITS:0] ty;
	logic signed [SCR_BITS:0] sc_sel;
	logic signed [RAW_BITS:0] tc_sel;
	logic [SCR_BITS-1:0]     sc_mag;
	logic [RAW_BITS-1:0]     tc_mag;
	logic                    q_neg;
	logic                    axis_y_sel;
	logic [NUM_BITS-1:0]     dividend;
	logic [DEN_BITS-1:0]     divisor;
	logic                    div_start;
	logic                    div_done;
	logic [NUM_BITS-1:0]     quotient;
	logic [SCALE_BITS-1:0]   q32;
	logic [SCALE_BITS-1:0]   q_signed;
	logic                    bad_setup;
	logic                    centred;
	logic                    run_end;
	logic                    map_start;
	logic                    map_axis_y;
	map_res_t                map_res;
	logic                    accept;
	logic                    out_free;

	assign in_item = in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);
	assign accept  = s_axis_tvalid && s_axis_tready;

	// Centred screen and touch offsets of the held calibration point.
	always_comb begin
		mid_x = screen_w_q >> 1;
		mid_y = screen_h_q >> 1;
		sx = $signed({1'b0, item_q.target_x}) - $signed({1'b0, mid_x});
		sy = $signed({1'b0, item_q.target_y}) - $signed({1'b0, mid_y});
		tx = $signed({1'b0, item_q.raw_x} - RAW_MID);
		ty = $signed({1'b0, item_q.raw_y} - RAW_MID);
		bad_setup = (point_count_q == '0) || (point_count_q > CNT_BITS'(MAX_POINTS))
			|| (screen_w_q == '0) || (screen_h_q == '0);
		centred = (sx == '0) || (sy == '0) || (tx == '0) || (ty == '0);
		run_end = ({1'b0, points_seen_q} + 1'b1) >= {1'b0, point_count_q};
	end

	// Divider operand select: Y axis in its own start and wait states.
	always_comb begin
		axis_y_sel = (state_q == S_DIV_Y) || (state_q == S_WAIT_Y);
		sc_sel     = axis_y_sel ? sy : sx;
		tc_sel     = axis_y_sel ? ty : tx;
		sc_mag     = sc_sel[SCR_BITS] ? SCR_BITS'(-sc_sel) : sc_sel[SCR_BITS-1:0];
		tc_mag     = tc_sel[RAW_BITS] ? RAW_BITS'(-tc_sel) : tc_sel[RAW_BITS-1:0];
		q_neg      = sc_sel[SCR_BITS] ^ tc_sel[RAW_BITS];
		dividend   = {sc_mag, {FRAC_BITS{1'b0}}};
		divisor    = DEN_BITS'(tc_mag) * DEN_BITS'(point_count_q);
		div_start  = (state_q == S_DIV_X) || (state_q == S_DIV_Y);
		q32        = SCALE_BITS'(quotient);
		q_signed   = q_neg ? -q32 : q32;
	end

	assign map_start  = (state_q == S_MAP_X) || (state_q == S_MAP_Y);
	assign map_axis_y = (state_q == S_MAP_Y);

	tcm_div #(
		.NUM_BITS(NUM_BITS),
		.DEN_BITS(DEN_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	tcm_mapper #(
		.FRAC_BITS(FRAC_BITS)
	) u_mapper (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (map_start),
		.axis_y (map_axis_y),
		.raw    (map_axis_y ? item_q.raw_y : item_q.raw_x),
		.scale  (map_axis_y ? scale_y_q : scale_x_q),
		.origin (map_axis_y ? origin_y_q : origin_x_q),
		.res    (map_res)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
			screen_w_q    <= SCREEN_W_RST;
			screen_h_q    <= SCREEN_H_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_POINT_COUNT:   point_count_q <= cfg_data[CNT_BITS-1:0];
				REG_SCREEN_WIDTH:  screen_w_q    <= cfg_data;
				REG_SCREEN_HEIGHT: screen_h_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			scale_x_q     <= '0;
			scale_y_q     <= '0;
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			sum_x_q       <= '0;
			sum_y_q       <= '0;
			points_seen_q <= '0;
			run_failed_q  <= 1'b0;
			out_valid_q   <= 1'b0;
			item_q        <= '0;
			res_q         <= '0;
			res_done_q    <= 1'b0;
			out_q         <= '0;
			out_last_q    <= 1'b0;
		end else begin
			// Load the output register from emit, else drop it once taken.
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						item_q     <= in_item;
						res_q      <= '{calib_ok: 1'b0, pos_y: '0, pos_x: '0,
							touch_valid: !s_axis_tuser && !in_item.pen_up};
						res_done_q <= 1'b0;
						if (s_axis_tuser) begin
							state_q <= S_CAL;
						end else if (in_item.pen_up) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_MAP_X;
						end
					end
				end
				S_MAP_X: state_q <= S_MAP_Y;
				S_MAP_Y: state_q <= S_MAP_WAIT;
				S_MAP_WAIT: begin
					if (map_res.valid) begin
						if (map_res.axis_y) begin
							res_q.pos_y <= map_res.pos;
							state_q     <= S_EMIT;
						end else begin
							res_q.pos_x <= map_res.pos;
						end
					end
				end
				S_CAL: begin
					// A new run starts from empty sums.
					if (points_seen_q == '0) begin
						sum_x_q <= '0;
						sum_y_q <= '0;
					end
					if (bad_setup || centred) begin
						run_failed_q <= 1'b1;
						state_q      <= S_END;
					end else begin
						if (points_seen_q == '0) begin
							run_failed_q <= 1'b0;
						end
						state_q <= S_DIV_X;
					end
				end
				S_DIV_X: state_q <= S_WAIT_X;
				S_WAIT_X: begin
					if (div_done) begin
						sum_x_q <= sum_x_q + q_signed;
						state_q <= S_DIV_Y;
					end
				end
				S_DIV_Y: state_q <= S_WAIT_Y;
				S_WAIT_Y: begin
					if (div_done) begin
						sum_y_q <= sum_y_q + q_signed;
						state_q <= S_END;
					end
				end
				S_END: begin
					if (run_end) begin
						points_seen_q <= '0;
						res_done_q    <= 1'b1;
						if (!run_failed_q) begin
							scale_x_q      <= sum_x_q;
							scale_y_q      <= sum_y_q;
							origin_x_q     <= mid_x;
							origin_y_q     <= mid_y;
							res_q.calib_ok <= 1'b1;
						end
					end else begin
						points_seen_q <= points_seen_q + 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// Hold until the output register frees.
					if (out_free) begin
						out_q      <= res_q;
						out_last_q <= res_done_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(32 - $bits(out_item_t))'(0), out_q};
	assign m_axis_tlast  = out_last_q;
	assign cfg_ready     = 1'b1;

	`TCM_ASSERT_IMP(a_div_done_in_wait, div_done, state_q == S_WAIT_X || state_q == S_WAIT_Y, "divider result outside a wait state")
	`TCM_ASSERT_IMP(a_map_res_in_map, map_res.valid, state_q == S_MAP_Y || state_q == S_MAP_WAIT, "mapper result outside mapping")
	`TCM_ASSERT_NXT(a_emit_holds, state_q == S_EMIT && out_valid_q && !m_axis_tready, state_q == S_EMIT && out_valid_q, "result overwrote a pending output")
	`TCM_ASSERT_IMP(a_ok_needs_done, out_valid_q && out_q.calib_ok, out_last_q && !out_q.touch_valid, "calib_ok without calib_done")
	`TCM_ASSERT_IMP(a_touch_is_sample, out_valid_q && out_q.touch_valid, !out_last_q, "touch result marked as run end")

endmodule
`default_nettype wire
